@@ rtl/tefr_pkg.sv @@
`timescale 1ns / 1ps
package tefr_pkg;

   // One input transfer: start or step command plus vertex data
   typedef struct packed {
      logic               command;
      logic signed [15:0] v0_x;
      logic signed [15:0] v0_y;
      logic [23:0]        v0_colour;
      logic signed [15:0] v1_x;
      logic signed [15:0] v1_y;
      logic [23:0]        v1_colour;
      logic signed [15:0] v2_x;
      logic signed [15:0] v2_y;
      logic [23:0]        v2_colour;
   } req_type;

   // One result transfer: a pixel of the bounding box
   typedef struct packed {
      logic [9:0] pixel_x;
      logic [9:0] pixel_y;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       covered;
      logic       last;
   } rsp_type;

   // Command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // Register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [10:0] WIDTH_RESET  = 11'd640;
   localparam logic [10:0] HEIGHT_RESET = 11'd480;

   // Command queue between front and back
   localparam int QDEPTH = 2;
   localparam int QAW    = 1;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_AREA,
      ST_EDGE,
      ST_DECIDE,
      ST_MAC,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

@@ rtl/tefr_front.sv @@
`timescale 1ns / 1ps
module tefr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tefr_pkg::req_type req_data,
   output logic              q_valid,
   input  logic              q_ready,
   output tefr_pkg::req_type q_data
);

   tefr_pkg::req_type           mem_ff [tefr_pkg::QDEPTH];
   logic [tefr_pkg::QAW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [tefr_pkg::QAW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [tefr_pkg::QAW:0]      count_ff, count_in;
   logic                        push, pop;

   // accept while the queue has room
   assign req_ready = (count_ff != (tefr_pkg::QAW+1)'(tefr_pkg::QDEPTH));
   assign q_valid   = (count_ff != '0);
   assign q_data    = mem_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (!push && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= req_data;
   end

endmodule

@@ rtl/tefr_edge.sv @@
`timescale 1ns / 1ps
module tefr_edge #(
   parameter int CW = 10
) (
   input  logic [CW-1:0]          ax,
   input  logic [CW-1:0]          ay,
   input  logic [CW-1:0]          bx,
   input  logic [CW-1:0]          by,
   input  logic [CW-1:0]          cx,
   input  logic [CW-1:0]          cy,
   output logic signed [2*CW+2:0] value
);

   localparam int DW = CW + 1;
   localparam int PW = 2 * DW;

   logic signed [DW-1:0] d_cbx, d_bay, d_cby, d_bax;
   logic signed [PW-1:0] p0, p1;

   // E(a,b,c) = (c.x-b.x)*(b.y-a.y) - (c.y-b.y)*(b.x-a.x)
   always_comb begin
      d_cbx = $signed({1'b0, cx}) - $signed({1'b0, bx});
      d_bay = $signed({1'b0, by}) - $signed({1'b0, ay});
      d_cby = $signed({1'b0, cy}) - $signed({1'b0, by});
      d_bax = $signed({1'b0, bx}) - $signed({1'b0, ax});
      p0    = d_cbx * d_bay;
      p1    = d_cby * d_bax;
      value = (PW+1)'(p0) - (PW+1)'(p1);
   end

endmodule

@@ rtl/tefr_back.sv @@
`timescale 1ns / 1ps
module tefr_back #(
   parameter int MAX_DIM = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  tefr_pkg::req_type q_data,
   input  logic [10:0]       cfg_width,
   input  logic [10:0]       cfg_height,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tefr_pkg::rsp_type rsp_data
);

   localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int EW = 2 * (CW + 1) + 1;
   localparam int NW = EW + 10;

   tefr_pkg::state_type state_ff, state_in;
   logic [2:0]          cnt_ff, cnt_in;
   logic [1:0]          ch_ff, ch_in;
   tefr_pkg::req_type   cur_ff, cur_in;
   logic [CW-1:0]       vx_ff [3];
   logic [CW-1:0]       vx_in [3];
   logic [CW-1:0]       vy_ff [3];
   logic [CW-1:0]       vy_in [3];
   logic [23:0]         rgb_ff [3];
   logic [23:0]         rgb_in [3];
   logic signed [EW-1:0] area_ff, area_in;
   logic [CW-1:0]       xmin_ff, xmin_in, xmax_ff, xmax_in;
   logic [CW-1:0]       ymin_ff, ymin_in, ymax_ff, ymax_in;
   logic [CW-1:0]       col_ff, col_in, row_ff, row_in;
   logic                busy_ff, busy_in;
   logic signed [EW-1:0] e_ff [3];
   logic signed [EW-1:0] e_in [3];
   logic [NW-1:0]       acc_ff, acc_in;
   logic [7:0]          quot_ff, quot_in;
   logic [7:0]          chan_ff [3];
   logic [7:0]          chan_in [3];
   logic                cov_ff, cov_in;
   logic                out_valid_ff, out_valid_in;
   tefr_pkg::rsp_type   out_data_ff, out_data_in;

   // datapath nets
   logic signed [15:0]  n_raw, n_clamp;
   logic [10:0]         dim_raw;
   logic [CW-1:0]       dim_m1;
   logic [15:0]         n_off;
   logic [15+CW:0]      map_prod;
   logic [CW-1:0]       mapped;
   logic [1:0]          k_sel, k_next;
   logic [CW-1:0]       ex_a, ey_a, ex_b, ey_b, ex_c, ey_c;
   logic signed [EW-1:0] edge_val;
   logic signed [EW-1:0] w2;
   logic [EW-2:0]       weight;
   logic [7:0]          cbyte;
   logic [EW+6:0]       mac_prod;
   logic [NW-1:0]       div_sub;
   logic [7:0]          quot_nx;
   logic                is_last, cov_w;

   tefr_edge #(.CW(CW)) u_edge (
      .ax(ex_a), .ay(ey_a), .bx(ex_b), .by(ey_b), .cx(ex_c), .cy(ey_c),
      .value(edge_val)
   );

   assign q_ready   = (state_ff == tefr_pkg::ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // coordinate map: clamp, offset, scale by (size-1), >> 15
   always_comb begin
      case (cnt_ff)
         3'd0:    n_raw = cur_ff.v0_x;
         3'd1:    n_raw = cur_ff.v0_y;
         3'd2:    n_raw = cur_ff.v1_x;
         3'd3:    n_raw = cur_ff.v1_y;
         3'd4:    n_raw = cur_ff.v2_x;
         default: n_raw = cur_ff.v2_y;
      endcase
      if (n_raw < -16'sd16384) n_clamp = -16'sd16384;
      else if (n_raw > 16'sd16384) n_clamp = 16'sd16384;
      else n_clamp = n_raw;
      n_off   = 16'(17'($signed({n_clamp[15], n_clamp})) + 17'd16384);
      dim_raw = cnt_ff[0] ? cfg_height : cfg_width;
      if (dim_raw == '0) dim_m1 = '0;
      else if (32'(dim_raw) > MAX_DIM) dim_m1 = CW'(MAX_DIM - 1);
      else dim_m1 = CW'(dim_raw - 11'd1);
      map_prod = (16+CW)'(n_off) * (16+CW)'(dim_m1);
      mapped   = map_prod[15 +: CW];
   end

   // edge unit operand selection
   always_comb begin
      k_sel  = (cnt_ff[1:0] == 2'd3) ? 2'd0 : cnt_ff[1:0];
      k_next = (k_sel == 2'd2) ? 2'd0 : k_sel + 2'd1;
      if (state_ff == tefr_pkg::ST_AREA) begin
         ex_a = vx_ff[0]; ey_a = vy_ff[0];
         ex_b = vx_ff[1]; ey_b = vy_ff[1];
         ex_c = vx_ff[2]; ey_c = vy_ff[2];
      end else begin
         ex_a = vx_ff[k_sel];  ey_a = vy_ff[k_sel];
         ex_b = vx_ff[k_next]; ey_b = vy_ff[k_next];
         ex_c = col_ff;        ey_c = row_ff;
      end
   end

   // weight times channel byte, restoring divide step
   always_comb begin
      w2 = area_ff - e_ff[1] - e_ff[2];
      case (k_sel)
         2'd0:    weight = e_ff[1][EW-2:0];
         2'd1:    weight = e_ff[2][EW-2:0];
         default: weight = w2[EW-2:0];
      endcase
      case (ch_ff)
         2'd0:    cbyte = rgb_ff[k_sel][23:16];
         2'd1:    cbyte = rgb_ff[k_sel][15:8];
         default: cbyte = rgb_ff[k_sel][7:0];
      endcase
      mac_prod = (EW+7)'(weight) * (EW+7)'(cbyte);
      div_sub  = NW'(area_ff[EW-2:0]) << cnt_ff;
      quot_nx  = quot_ff;
      if (acc_ff >= div_sub) quot_nx[cnt_ff] = 1'b1;
      is_last  = (col_ff == xmax_ff) && (row_ff == ymax_ff);
      cov_w    = !e_ff[0][EW-1] && !e_ff[1][EW-1] && !e_ff[2][EW-1] && (area_ff != '0);
   end

   // sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ch_in        = ch_ff;
      cur_in       = cur_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      rgb_in       = rgb_ff;
      area_in      = area_ff;
      xmin_in      = xmin_ff;
      xmax_in      = xmax_ff;
      ymin_in      = ymin_ff;
      ymax_in      = ymax_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      busy_in      = busy_ff;
      e_in         = e_ff;
      acc_in       = acc_ff;
      quot_in      = quot_ff;
      chan_in      = chan_ff;
      cov_in       = cov_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_data_in  = out_data_ff;
      case (state_ff)
         tefr_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (q_valid) begin
               if (q_data.command == tefr_pkg::CMD_START) begin
                  cur_in   = q_data;
                  rgb_in[0] = q_data.v0_colour;
                  rgb_in[1] = q_data.v1_colour;
                  rgb_in[2] = q_data.v2_colour;
                  state_in = tefr_pkg::ST_MAP;
               end else if (busy_ff) begin
                  state_in = tefr_pkg::ST_EDGE;
               end
            end
         end
         tefr_pkg::ST_MAP: begin
            if (cnt_ff[0]) vy_in[cnt_ff[2:1]] = mapped;
            else vx_in[cnt_ff[2:1]] = mapped;
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd5) state_in = tefr_pkg::ST_AREA;
         end
         tefr_pkg::ST_AREA: begin
            area_in = edge_val;
            xmin_in = vx_ff[0];
            xmax_in = vx_ff[0];
            ymin_in = vy_ff[0];
            ymax_in = vy_ff[0];
            for (int i = 1; i < 3; i++) begin
               if (vx_ff[i] < xmin_in) xmin_in = vx_ff[i];
               if (vx_ff[i] > xmax_in) xmax_in = vx_ff[i];
               if (vy_ff[i] < ymin_in) ymin_in = vy_ff[i];
               if (vy_ff[i] > ymax_in) ymax_in = vy_ff[i];
            end
            col_in   = xmin_in;
            row_in   = ymin_in;
            busy_in  = 1'b1;
            state_in = tefr_pkg::ST_IDLE;
         end
         tefr_pkg::ST_EDGE: begin
            e_in[k_sel] = edge_val;
            cnt_in      = cnt_ff + 3'd1;
            if (cnt_ff == 3'd2) state_in = tefr_pkg::ST_DECIDE;
         end
         tefr_pkg::ST_DECIDE: begin
            cov_in     = cov_w;
            chan_in[0] = '0;
            chan_in[1] = '0;
            chan_in[2] = '0;
            cnt_in     = '0;
            ch_in      = '0;
            acc_in     = '0;
            state_in   = cov_w ? tefr_pkg::ST_MAC : tefr_pkg::ST_OUT;
         end
         tefr_pkg::ST_MAC: begin
            acc_in = acc_ff + NW'(mac_prod);
            if (cnt_ff == 3'd2) begin
               cnt_in   = 3'd7;
               quot_in  = '0;
               state_in = tefr_pkg::ST_DIV;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         tefr_pkg::ST_DIV: begin
            quot_in = quot_nx;
            if (acc_ff >= div_sub) acc_in = acc_ff - div_sub;
            cnt_in = cnt_ff - 3'd1;
            if (cnt_ff == 3'd0) begin
               chan_in[ch_ff] = quot_nx;
               acc_in         = '0;
               cnt_in         = '0;
               if (ch_ff == 2'd2) begin
                  state_in = tefr_pkg::ST_OUT;
               end else begin
                  ch_in    = ch_ff + 2'd1;
                  state_in = tefr_pkg::ST_MAC;
               end
            end
         end
         tefr_pkg::ST_OUT: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in        = 1'b1;
               out_data_in.pixel_x = 10'(col_ff);
               out_data_in.pixel_y = 10'(row_ff);
               out_data_in.red     = chan_ff[0];
               out_data_in.green   = chan_ff[1];
               out_data_in.blue    = chan_ff[2];
               out_data_in.covered = cov_ff;
               out_data_in.last    = is_last;
               if (is_last) begin
                  busy_in = 1'b0;
               end else if (col_ff >= xmax_ff) begin
                  col_in = xmin_ff;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
               state_in = tefr_pkg::ST_IDLE;
            end
         end
         default: state_in = tefr_pkg::ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tefr_pkg::ST_IDLE;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         ch_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         cnt_ff       <= cnt_in;
         ch_ff        <= ch_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      rgb_ff      <= rgb_in;
      area_ff     <= area_in;
      xmin_ff     <= xmin_in;
      xmax_ff     <= xmax_in;
      ymin_ff     <= ymin_in;
      ymax_ff     <= ymax_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      e_ff        <= e_in;
      acc_ff      <= acc_in;
      quot_ff     <= quot_in;
      chan_ff     <= chan_in;
      cov_ff      <= cov_in;
      out_data_ff <= out_data_in;
   end

endmodule

@@ rtl/triangle_edge_function_rasterizer_top.sv @@
`timescale 1ns / 1ps
// Start transfer: from queue head to loaded triangle by mapping each vertex coordinate, then the area.
// Step transfer: a covered pixel goes through each edge, then for each channel a multiply-accumulate
// over the vertices and a restoring divide; an uncovered pixel skips the channels.
// One item is worked at a time; a 2-entry command queue and the result register
// let input and output stall independently. Reset is synchronous, active high:
// queue empty, no triangle loaded, no result pending, screen 640 x 480.
module triangle_edge_function_rasterizer_top #(
   parameter int MAX_DIM = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  tefr_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output tefr_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tefr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [10:0]                      csr_data
);

   logic              q_valid, q_ready;
   tefr_pkg::req_type q_data;
   logic [10:0]       width_ff, height_ff;

   // screen size registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= tefr_pkg::WIDTH_RESET;
         height_ff <= tefr_pkg::HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == tefr_pkg::CSR_WIDTH) width_ff <= csr_data;
         else if (csr_index == tefr_pkg::CSR_HEIGHT) height_ff <= csr_data;
      end
   end

   tefr_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
   );

   tefr_back #(.MAX_DIM(MAX_DIM)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
      .cfg_width(width_ff), .cfg_height(height_ff),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

endmodule

@@ rtl/tefr_checker.sv @@
`timescale 1ns / 1ps
module tefr_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input tefr_pkg::rsp_type rsp_data
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // uncovered pixel carries black
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.covered |->
         rsp_data.red == 8'd0 && rsp_data.green == 8'd0 && rsp_data.blue == 8'd0)
      else $error("uncovered pixel with colour");

   // reset leaves no result pending
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind triangle_edge_function_rasterizer_top tefr_checker u_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
module tb;

   localparam int DIM_LIMIT = 1024;
   localparam logic [tefr_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [tefr_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   tefr_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   tefr_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [tefr_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [10:0] csr_data = '0;

   triangle_edge_function_rasterizer_top #(.MAX_DIM(DIM_LIMIT)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the rasterizer
   logic [10:0] scr_w = tefr_pkg::WIDTH_RESET;
   logic [10:0] scr_h = tefr_pkg::HEIGHT_RESET;
   longint vx[3], vy[3];
   logic [23:0] vrgb[3];
   longint tri_area, xmin, xmax, ymin, ymax, col, row;
   bit tri_loaded = 0;

   tefr_pkg::req_type item_q[$];
   tefr_pkg::rsp_type pixel_q[$];
   int errors = 0;
   bit calm = 0;
   int items_made = 0;

   function automatic longint dim_of(logic [10:0] d);
      if (d < 11'd1) return 1;
      if (longint'(d) > DIM_LIMIT) return DIM_LIMIT;
      return longint'(d);
   endfunction

   function automatic longint to_screen(logic signed [15:0] raw, longint size);
      longint n;
      n = longint'(raw);
      if (n < -16384) n = -16384;
      if (n > 16384) n = 16384;
      return ((n + 16384) * (size - 1)) >> 15;
   endfunction

   function automatic longint edge_val(longint ax, longint ay, longint bx, longint by,
                                       longint cx, longint cy);
      return (cx - bx) * (by - ay) - (cy - by) * (bx - ax);
   endfunction

   function automatic longint lo3(longint a, longint b, longint c);
      longint m;
      m = a < b ? a : b;
      return m < c ? m : c;
   endfunction

   function automatic longint hi3(longint a, longint b, longint c);
      longint m;
      m = a > b ? a : b;
      return m > c ? m : c;
   endfunction

   // Apply one accepted item to the shadow state, queue the pixel it yields
   task automatic raster_step(tefr_pkg::req_type r);
      longint w, h, e0, e1, e2, w2, num, q;
      tefr_pkg::rsp_type px;
      int sh;
      if (r.command == tefr_pkg::CMD_START) begin
         w = dim_of(scr_w);
         h = dim_of(scr_h);
         vx[0] = to_screen(r.v0_x, w); vy[0] = to_screen(r.v0_y, h);
         vx[1] = to_screen(r.v1_x, w); vy[1] = to_screen(r.v1_y, h);
         vx[2] = to_screen(r.v2_x, w); vy[2] = to_screen(r.v2_y, h);
         vrgb[0] = r.v0_colour; vrgb[1] = r.v1_colour; vrgb[2] = r.v2_colour;
         xmin = lo3(vx[0], vx[1], vx[2]); xmax = hi3(vx[0], vx[1], vx[2]);
         ymin = lo3(vy[0], vy[1], vy[2]); ymax = hi3(vy[0], vy[1], vy[2]);
         tri_area = edge_val(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
         col = xmin;
         row = ymin;
         tri_loaded = 1;
      end else if (tri_loaded) begin
         e0 = edge_val(vx[0], vy[0], vx[1], vy[1], col, row);
         e1 = edge_val(vx[1], vy[1], vx[2], vy[2], col, row);
         e2 = edge_val(vx[2], vy[2], vx[0], vy[0], col, row);
         px = '0;
         px.pixel_x = col[9:0];
         px.pixel_y = row[9:0];
         px.covered = (e0 >= 0 && e1 >= 0 && e2 >= 0 && tri_area != 0);
         px.last = (col == xmax && row == ymax);
         if (px.covered) begin
            w2 = tri_area - e1 - e2;
            for (int ch = 0; ch < 3; ch++) begin
               sh = 16 - 8 * ch;
               num = e1 * longint'(vrgb[0][sh +: 8]) + e2 * longint'(vrgb[1][sh +: 8])
                     + w2 * longint'(vrgb[2][sh +: 8]);
               q = num / tri_area;
               // floor division
               if ((num % tri_area != 0) && ((num < 0) != (tri_area < 0))) q = q - 1;
               if (q < 0) q = 0;
               if (q > 255) q = 255;
               case (ch)
                  0: px.red = q[7:0];
                  1: px.green = q[7:0];
                  default: px.blue = q[7:0];
               endcase
            end
         end
         pixel_q.push_back(px);
         if (px.last) begin
            tri_loaded = 0;
         end else if (col >= xmax) begin
            col = xmin;
            row = row + 1;
         end else begin
            col = col + 1;
         end
      end
   endtask

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = int'($urandom_range(0, 99));
      if (r < 70) return 0;
      if (r < 94) return int'($urandom_range(1, 3));
      return int'($urandom_range(10, 40));
   endfunction

   // Request driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && req_ready) raster_step(req_data);
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (item_q.size() > 0) begin
               req_data <= item_q.pop_front();
               req_valid <= 1'b1;
               send_gap <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Result monitor with random back-pressure
   int stall = 0;
   always @(posedge clock) begin
      tefr_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pixel_q.size() == 0) begin
               report("unexpected pixel x", rsp_data.pixel_x, -1);
            end else begin
               want = pixel_q.pop_front();
               if (rsp_data.pixel_x !== want.pixel_x) report("pixel_x", rsp_data.pixel_x, want.pixel_x);
               if (rsp_data.pixel_y !== want.pixel_y) report("pixel_y", rsp_data.pixel_y, want.pixel_y);
               if (rsp_data.red !== want.red) report("red", rsp_data.red, want.red);
               if (rsp_data.green !== want.green) report("green", rsp_data.green, want.green);
               if (rsp_data.blue !== want.blue) report("blue", rsp_data.blue, want.blue);
               if (rsp_data.covered !== want.covered) report("covered", rsp_data.covered, want.covered);
               if (rsp_data.last !== want.last) report("last", rsp_data.last, want.last);
            end
         end
         if (stall > 0) begin
            stall <= stall - 1;
            rsp_ready <= 1'b0;
         end else begin
            stall <= pick_gap();
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic tefr_pkg::req_type make_start(int x0, int y0, int x1, int y1,
                                                    int x2, int y2, logic [23:0] c0,
                                                    logic [23:0] c1, logic [23:0] c2);
      tefr_pkg::req_type r;
      r = '0;
      r.command = tefr_pkg::CMD_START;
      r.v0_x = 16'(x0); r.v0_y = 16'(y0); r.v0_colour = c0;
      r.v1_x = 16'(x1); r.v1_y = 16'(y1); r.v1_colour = c1;
      r.v2_x = 16'(x2); r.v2_y = 16'(y2); r.v2_colour = c2;
      return r;
   endfunction

   task automatic add_steps(int n);
      tefr_pkg::req_type r;
      for (int i = 0; i < n; i++) begin
         r = '0;
         r.command = tefr_pkg::CMD_STEP;
         // payload of a step is don't-care; toggle it anyway
         r.v0_x = 16'($urandom); r.v2_colour = 24'($urandom);
         item_q.push_back(r);
      end
   endtask

   function automatic logic signed [15:0] pick_coord();
      int k;
      k = int'($urandom_range(0, 9));
      if (k == 0) return 16'($urandom);
      if (k == 1) begin
         case ($urandom_range(0, 3))
            0: return -16'sd16384;
            1: return 16'sd16384;
            2: return -16'sd32768;
            default: return 16'sd32767;
         endcase
      end
      return 16'(int'($urandom_range(0, 32768)) - 16384);
   endfunction

   // One triangle: start plus a full scan, an aborted scan or an overrun
   task automatic add_triangle();
      tefr_pkg::req_type r;
      longint w, h, sx[3], sy[3], box;
      int n;
      r = make_start(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                     pick_coord(), pick_coord(), 24'($urandom), 24'($urandom),
                     24'($urandom));
      case ($urandom_range(0, 9))
         0: begin r.v1_x = r.v0_x; r.v1_y = r.v0_y; end
         1: begin r.v2_x = r.v0_x; r.v1_x = r.v0_x; end
         default: ;
      endcase
      w = dim_of(scr_w);
      h = dim_of(scr_h);
      sx[0] = to_screen(r.v0_x, w); sy[0] = to_screen(r.v0_y, h);
      sx[1] = to_screen(r.v1_x, w); sy[1] = to_screen(r.v1_y, h);
      sx[2] = to_screen(r.v2_x, w); sy[2] = to_screen(r.v2_y, h);
      box = (hi3(sx[0], sx[1], sx[2]) - lo3(sx[0], sx[1], sx[2]) + 1)
          * (hi3(sy[0], sy[1], sy[2]) - lo3(sy[0], sy[1], sy[2]) + 1);
      item_q.push_back(r);
      if (box <= 60 && $urandom_range(0, 9) > 0) n = int'(box) + int'($urandom_range(0, 2));
      else n = int'($urandom_range(3, 30));
      add_steps(n);
      items_made += n + 1;
   endtask

   task automatic write_reg(logic [tefr_pkg::CSR_IDX_W-1:0] idx, logic [10:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == tefr_pkg::CSR_WIDTH) scr_w = val;
      else if (idx == tefr_pkg::CSR_HEIGHT) scr_h = val;
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (item_q.size() > 0 || req_valid || pixel_q.size() > 0) @(posedge clock);
      // a trailing start yields nothing; let the block finish loading it
      repeat (60) @(posedge clock);
   endtask

   initial begin
      logic [10:0] wl[$], hl[$];
      int p;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: 2 x 2 screen, steps while idle, both windings, saturation, restart
      write_reg(tefr_pkg::CSR_WIDTH, 11'd2);
      write_reg(tefr_pkg::CSR_HEIGHT, 11'd2);
      add_steps(1);
      item_q.push_back(make_start(-16384, -16384, 16384, -16384, -16384, 16384,
                                  24'hFFFFFF, 24'h000000, 24'hFF00FF));
      add_steps(4);
      item_q.push_back(make_start(-16384, -16384, -16384, 16384, 16384, -16384,
                                  24'h123456, 24'hFFFFFF, 24'h00FF00));
      add_steps(4);
      item_q.push_back(make_start(-32768, 32767, 32767, -32768, 16384, 16384,
                                  24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
      add_steps(2);
      item_q.push_back(make_start(0, 0, 0, 0, 0, 0, 24'hAAAAAA, 24'h555555, 24'h0F0F0F));
      add_steps(2);
      drain();

      // Out-of-range indexes are ignored
      write_reg(CSR_SPARE_A, 11'h7FF);
      write_reg(CSR_SPARE_B, 11'h000);
      wl = '{11'd0, 11'd2047, 11'd1024, 11'd1, 11'd1023, 11'd640};
      hl = '{11'd0, 11'd2047, 11'd1, 11'd1024, 11'd5, 11'd480};
      p = 0;
      while (items_made < 1300) begin
         if (p < wl.size()) begin
            write_reg(tefr_pkg::CSR_WIDTH, wl[p]);
            write_reg(tefr_pkg::CSR_HEIGHT, hl[p]);
         end else begin
            write_reg(tefr_pkg::CSR_WIDTH, 11'($urandom_range(1, 24)));
            write_reg(tefr_pkg::CSR_HEIGHT, 11'($urandom_range(1, 24)));
         end
         calm = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(3, 8)) add_triangle();
         drain();
         p++;
      end
      if (errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
